// ----- design/gbic_pkg.sv -----
// Shared widths, codes and control types of the grid bilinear index-to-coordinate mapper.
package gbic_pkg;

	// Fixed-point format of indices and coordinates
	localparam int FRAC_BITS = 16;
	localparam int C_W       = 32;                  // coordinate and index width
	localparam int IDX_W     = 8;                   // node column / row / cell count width
	localparam int UV_W      = FRAC_BITS + 1;       // fraction, 0 .. 1.0 inclusive
	localparam int D_W       = C_W + 1;             // difference of two coordinates
	localparam int M_W       = D_W + UV_W + 1;      // difference times fraction
	localparam int T_W       = C_W + FRAC_BITS;     // one-axis blend, Q32.F
	localparam int R_W       = 2 * FRAC_BITS + 3;   // remainder difference times fraction
	localparam int CFG_AW    = 1;

	// Coordinate lanes carried side by side
	localparam int LANES  = 2;
	localparam int LANE_X = 0;
	localparam int LANE_Y = 1;

	// Command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Register indexes
	localparam logic [CFG_AW-1:0] REG_CELLS_ACROSS = 1'd0;
	localparam logic [CFG_AW-1:0] REG_CELLS_DOWN   = 1'd1;

	// Clamped index split into cell and fraction
	typedef struct packed {
		logic [IDX_W-1:0] cell_idx;
		logic [UV_W-1:0]  frac;
		logic             ok;
	} split_t;

	// Control that travels with each beat through the blend pipeline
	typedef struct packed {
		logic vld;
		logic ok;
	} tag_t;

endpackage

// ----- design/gbic_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module gbic_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- design/gbic_split.sv -----
// Clamps one fractional index to the cell range and splits it into cell and fraction.
module gbic_split (
	input  logic signed [gbic_pkg::C_W-1:0]   q,
	input  logic        [gbic_pkg::IDX_W-1:0] cells,
	output gbic_pkg::split_t                  res
);
	import gbic_pkg::*;

	localparam int X_W = C_W + 1;

	logic signed [X_W-1:0] qx;
	logic signed [X_W-1:0] top;

	// Upper bound of the index is cells * 1.0
	assign qx  = X_W'(q);
	assign top = $signed(X_W'(cells) << FRAC_BITS);

	always_comb begin
		res.ok       = 1'b1;
		res.cell_idx = q[FRAC_BITS +: IDX_W];
		res.frac     = {1'b0, q[FRAC_BITS-1:0]};
		if (qx[X_W-1]) begin
			// below zero: pin to the first node
			res.ok       = 1'b0;
			res.cell_idx = '0;
			res.frac     = '0;
		end else if (qx > top) begin
			// above the grid: one LSB short of the far edge
			res.ok       = 1'b0;
			res.cell_idx = cells - IDX_W'(1);
			res.frac     = {1'b0, {FRAC_BITS{1'b1}}};
		end else if (qx == top) begin
			// exactly on the far edge: last cell with full fraction
			res.cell_idx = cells - IDX_W'(1);
			res.frac     = {1'b1, {FRAC_BITS{1'b0}}};
		end
	end

endmodule

// ----- design/gbic_blend.sv -----
// Pipelined exact-floor bilinear blend of four corners for the x and y lanes.
module gbic_blend (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  gbic_pkg::tag_t                                 tag,
	input  logic [gbic_pkg::UV_W-1:0]                      u,
	input  logic [gbic_pkg::UV_W-1:0]                      v,
	input  logic [gbic_pkg::LANES-1:0][gbic_pkg::C_W-1:0]  p00,
	input  logic [gbic_pkg::LANES-1:0][gbic_pkg::C_W-1:0]  p10,
	input  logic [gbic_pkg::LANES-1:0][gbic_pkg::C_W-1:0]  p01,
	input  logic [gbic_pkg::LANES-1:0][gbic_pkg::C_W-1:0]  p11,
	output gbic_pkg::tag_t                                 res_tag,
	output logic [gbic_pkg::LANES-1:0][gbic_pkg::C_W-1:0]  res
);
	import gbic_pkg::*;

	localparam int F = FRAC_BITS;

	// Control beats
	tag_t tag_s4, tag_s5, tag_s6, tag_s7, tag_s8, tag_s9, tag_s10;

	// Fractions
	logic [UV_W-1:0] u_s4;
	logic [UV_W-1:0] v_s4, v_s5, v_s6, v_s7;

	// Corner differences along i
	logic signed [D_W-1:0] dx0_s4 [LANES];
	logic signed [D_W-1:0] dx1_s4 [LANES];
	logic [C_W-1:0]        p00_s4 [LANES];
	logic [C_W-1:0]        p01_s4 [LANES];

	// Differences scaled by u
	logic signed [M_W-1:0] m0_s5  [LANES];
	logic signed [M_W-1:0] m1_s5  [LANES];
	logic [C_W-1:0]        p00_s5 [LANES];
	logic [C_W-1:0]        p01_s5 [LANES];

	// Row blends
	logic [T_W-1:0] t0_s6 [LANES];
	logic [T_W-1:0] t1_s6 [LANES];

	// Quotient and remainder differences along j
	logic signed [D_W-1:0]  dq_s7 [LANES];
	logic signed [UV_W-1:0] dr_s7 [LANES];
	logic [C_W-1:0]         q0_s7 [LANES];
	logic [F-1:0]           r0_s7 [LANES];

	// Differences scaled by v
	logic signed [M_W-1:0] mq_s8 [LANES];
	logic signed [R_W-1:0] mr_s8 [LANES];
	logic [C_W-1:0]        q0_s8 [LANES];
	logic [F-1:0]          r0_s8 [LANES];

	// Column blend of quotients and remainders
	logic [T_W-1:0] qs_s9 [LANES];
	logic [2*F-1:0] rs_s9 [LANES];

	logic [C_W-1:0] res_s10 [LANES];

	logic signed [UV_W:0] ue_s4;
	logic signed [UV_W:0] ve_s7;
	logic [2*F:0]         low_c [LANES];

	assign ue_s4 = $signed({1'b0, u_s4});
	assign ve_s7 = $signed({1'b0, v_s7});

	// Carry of the combined low fraction bits into the result
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			low_c[l] = {1'b0, qs_s9[l][F-1:0], {F{1'b0}}} + {1'b0, rs_s9[l]};
		end
	end

	// Advance control beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s4  <= '0;
			tag_s5  <= '0;
			tag_s6  <= '0;
			tag_s7  <= '0;
			tag_s8  <= '0;
			tag_s9  <= '0;
			tag_s10 <= '0;
		end else begin
			tag_s4  <= tag;
			tag_s5  <= tag_s4;
			tag_s6  <= tag_s5;
			tag_s7  <= tag_s6;
			tag_s8  <= tag_s7;
			tag_s9  <= tag_s8;
			tag_s10 <= tag_s9;
		end
	end

	// Advance the datapath
	always_ff @(posedge clk) begin
		u_s4 <= u;
		v_s4 <= v;
		v_s5 <= v_s4;
		v_s6 <= v_s5;
		v_s7 <= v_s6;
		for (int l = 0; l < LANES; l++) begin
			// differences of the corners along i
			dx0_s4[l] <= $signed({p10[l][C_W-1], p10[l]}) - $signed({p00[l][C_W-1], p00[l]});
			dx1_s4[l] <= $signed({p11[l][C_W-1], p11[l]}) - $signed({p01[l][C_W-1], p01[l]});
			p00_s4[l] <= p00[l];
			p01_s4[l] <= p01[l];

			// scale by u
			m0_s5[l]  <= dx0_s4[l] * ue_s4;
			m1_s5[l]  <= dx1_s4[l] * ue_s4;
			p00_s5[l] <= p00_s4[l];
			p01_s5[l] <= p01_s4[l];

			// row blends p0*1.0 + d*u
			t0_s6[l] <= T_W'(m0_s5[l]) + {p00_s5[l], {F{1'b0}}};
			t1_s6[l] <= T_W'(m1_s5[l]) + {p01_s5[l], {F{1'b0}}};

			// split rows into floor quotient and remainder, take differences
			dq_s7[l] <= $signed({t1_s6[l][T_W-1], t1_s6[l][T_W-1:F]})
				- $signed({t0_s6[l][T_W-1], t0_s6[l][T_W-1:F]});
			dr_s7[l] <= $signed({1'b0, t1_s6[l][F-1:0]}) - $signed({1'b0, t0_s6[l][F-1:0]});
			q0_s7[l] <= t0_s6[l][T_W-1:F];
			r0_s7[l] <= t0_s6[l][F-1:0];

			// scale by v
			mq_s8[l] <= dq_s7[l] * ve_s7;
			mr_s8[l] <= dr_s7[l] * ve_s7;
			q0_s8[l] <= q0_s7[l];
			r0_s8[l] <= r0_s7[l];

			// column blends of quotient and remainder parts
			qs_s9[l] <= T_W'(mq_s8[l]) + {q0_s8[l], {F{1'b0}}};
			rs_s9[l] <= (2*F)'(mr_s8[l]) + {r0_s8[l], {F{1'b0}}};

			// floor of the whole blend
			res_s10[l] <= qs_s9[l][T_W-1:F] + C_W'(low_c[l][2*F]);
		end
	end

	assign res_tag = tag_s10;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			res[l] = res_s10[l];
		end
	end

endmodule

// ----- design/grid_bilinear_index_to_coord.sv -----
// Top level: node store in four parity banks, index split and bilinear blend pipeline.
// Flow: a query accepted with start passes stages 1 to 3 and blend stages s4 to s10 before
// its result shows with done high; a write item lands in its node bank after stages 1 and 2.
// Throughput: one item per cycle; the four corner reads go to four banks split by row and
// column parity, so busy stays low and results are never held back.
// Reset clears all beat valid bits and sets both cell counts to their maximum; node banks
// are not cleared and must be written before they are read.
module grid_bilinear_index_to_coord #(
	parameter int NODES_ACROSS = 256,
	parameter int NODES_DOWN   = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 cmd,
	input  logic        [gbic_pkg::IDX_W-1:0]    node_col,
	input  logic        [gbic_pkg::IDX_W-1:0]    node_row,
	input  logic signed [gbic_pkg::C_W-1:0]      node_x,
	input  logic signed [gbic_pkg::C_W-1:0]      node_y,
	input  logic signed [gbic_pkg::C_W-1:0]      query_i,
	input  logic signed [gbic_pkg::C_W-1:0]      query_j,
	input  logic                                 cfg_we,
	input  logic        [gbic_pkg::CFG_AW-1:0]   cfg_index,
	input  logic        [gbic_pkg::IDX_W-1:0]    cfg_wdata,
	output logic                                 done,
	output logic signed [gbic_pkg::C_W-1:0]      out_x,
	output logic signed [gbic_pkg::C_W-1:0]      out_y,
	output logic                                 in_range
);
	import gbic_pkg::*;

	// Bank geometry: column and row bits beyond parity address inside a bank
	localparam int COL_BITS   = (NODES_ACROSS > 256) ? IDX_W : $clog2(NODES_ACROSS);
	localparam int ROW_BITS   = (NODES_DOWN > 256) ? IDX_W : $clog2(NODES_DOWN);
	localparam int HC_W       = (COL_BITS > 1) ? COL_BITS - 1 : 1;
	localparam int HR_W       = (ROW_BITS > 1) ? ROW_BITS - 1 : 1;
	localparam int BANK_AW    = HC_W + HR_W;
	localparam int BANK_DEPTH = 2 ** BANK_AW;
	localparam int BANKS      = 4;
	localparam int NODE_W     = 2 * C_W;

	localparam logic [IDX_W-1:0] MAX_ACROSS =
		IDX_W'((NODES_ACROSS - 1 > 255) ? 255 : NODES_ACROSS - 1);
	localparam logic [IDX_W-1:0] MAX_DOWN =
		IDX_W'((NODES_DOWN - 1 > 255) ? 255 : NODES_DOWN - 1);

	// Effective cell counts
	logic [IDX_W-1:0] cells_across_q;
	logic [IDX_W-1:0] cells_down_q;

	// Stage 1: captured beat
	logic                    vld_s1;
	logic                    cmd_s1;
	logic [IDX_W-1:0]        col_s1, row_s1;
	logic [C_W-1:0]          nx_s1, ny_s1;
	logic signed [C_W-1:0]   qi_s1, qj_s1;
	split_t                  si_c, sj_c;
	logic                    in_grid_c;

	// Stage 2: bank access
	logic                    wr_s2;
	logic                    qry_s2;
	logic [IDX_W-1:0]        col_s2, row_s2;
	logic [NODE_W-1:0]       wdata_s2;
	logic [UV_W-1:0]         u_s2, v_s2;
	logic                    ok_s2;

	logic [BANK_AW-1:0]      bank_addr [BANKS];
	logic                    bank_we   [BANKS];
	logic [NODE_W-1:0]       bank_rd   [BANKS];

	// Stage 3: corner routing
	logic                    qry_s3;
	logic                    ok_s3;
	logic [UV_W-1:0]         u_s3, v_s3;
	logic                    pi_s3, pj_s3;

	tag_t                               blend_tag;
	tag_t                               res_tag;
	logic [LANES-1:0][C_W-1:0]          c00, c10, c01, c11;
	logic [LANES-1:0][C_W-1:0]          res;

	assign busy = 1'b0;

	// Configuration writes, clamped to the usable cell range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_across_q <= MAX_ACROSS;
			cells_down_q   <= MAX_DOWN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CELLS_ACROSS: begin
					if (cfg_wdata == '0) begin
						cells_across_q <= IDX_W'(1);
					end else if (cfg_wdata > MAX_ACROSS) begin
						cells_across_q <= MAX_ACROSS;
					end else begin
						cells_across_q <= cfg_wdata;
					end
				end
				REG_CELLS_DOWN: begin
					if (cfg_wdata == '0) begin
						cells_down_q <= IDX_W'(1);
					end else if (cfg_wdata > MAX_DOWN) begin
						cells_down_q <= MAX_DOWN;
					end else begin
						cells_down_q <= cfg_wdata;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Stage 1: capture the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd;
		col_s1 <= node_col;
		row_s1 <= node_row;
		nx_s1  <= node_x;
		ny_s1  <= node_y;
		qi_s1  <= query_i;
		qj_s1  <= query_j;
	end

	// Clamp and split both indices
	gbic_split u_split_i (
		.q     (qi_s1),
		.cells (cells_across_q),
		.res   (si_c)
	);

	gbic_split u_split_j (
		.q     (qj_s1),
		.cells (cells_down_q),
		.res   (sj_c)
	);

	// Drop writes outside the grid
	assign in_grid_c = (32'(col_s1) < NODES_ACROSS) && (32'(row_s1) < NODES_DOWN);

	// Stage 2: register bank request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s2  <= 1'b0;
			qry_s2 <= 1'b0;
		end else begin
			wr_s2  <= vld_s1 && (cmd_s1 == CMD_WRITE) && in_grid_c;
			qry_s2 <= vld_s1 && (cmd_s1 == CMD_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		col_s2   <= (cmd_s1 == CMD_WRITE) ? col_s1 : si_c.cell_idx;
		row_s2   <= (cmd_s1 == CMD_WRITE) ? row_s1 : sj_c.cell_idx;
		wdata_s2 <= {nx_s1, ny_s1};
		u_s2     <= si_c.frac;
		v_s2     <= sj_c.frac;
		ok_s2    <= si_c.ok && sj_c.ok;
	end

	// Node banks by row and column parity; each corner of a cell hits a different bank
	for (genvar b = 0; b < BANKS; b++) begin : g_bank
		logic [IDX_W-1:0] col_b;
		logic [IDX_W-1:0] row_b;

		assign col_b = (col_s2[0] == b[0]) ? col_s2 : col_s2 + IDX_W'(1);
		assign row_b = (row_s2[0] == b[1]) ? row_s2 : row_s2 + IDX_W'(1);
		assign bank_addr[b] = {HR_W'(row_b >> 1), HC_W'(col_b >> 1)};
		assign bank_we[b]   = wr_s2 && ({row_s2[0], col_s2[0]} == 2'(b));

		gbic_ram #(
			.WIDTH (NODE_W),
			.DEPTH (BANK_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (bank_we[b]),
			.waddr (bank_addr[b]),
			.wdata (wdata_s2),
			.raddr (bank_addr[b]),
			.rdata (bank_rd[b])
		);
	end

	// Stage 3: hold the query beside the bank read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qry_s3 <= 1'b0;
			ok_s3  <= 1'b0;
		end else begin
			qry_s3 <= qry_s2;
			ok_s3  <= ok_s2;
		end
	end

	always_ff @(posedge clk) begin
		u_s3  <= u_s2;
		v_s3  <= v_s2;
		pi_s3 <= col_s2[0];
		pj_s3 <= row_s2[0];
	end

	// Route banks to corners by cell parity
	always_comb begin
		c00[LANE_X] = bank_rd[{pj_s3, pi_s3}][NODE_W-1:C_W];
		c10[LANE_X] = bank_rd[{pj_s3, ~pi_s3}][NODE_W-1:C_W];
		c01[LANE_X] = bank_rd[{~pj_s3, pi_s3}][NODE_W-1:C_W];
		c11[LANE_X] = bank_rd[{~pj_s3, ~pi_s3}][NODE_W-1:C_W];
		c00[LANE_Y] = bank_rd[{pj_s3, pi_s3}][C_W-1:0];
		c10[LANE_Y] = bank_rd[{pj_s3, ~pi_s3}][C_W-1:0];
		c01[LANE_Y] = bank_rd[{~pj_s3, pi_s3}][C_W-1:0];
		c11[LANE_Y] = bank_rd[{~pj_s3, ~pi_s3}][C_W-1:0];
	end

	assign blend_tag.vld = qry_s3;
	assign blend_tag.ok  = ok_s3;

	gbic_blend u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag     (blend_tag),
		.u       (u_s3),
		.v       (v_s3),
		.p00     (c00),
		.p10     (c10),
		.p01     (c01),
		.p11     (c11),
		.res_tag (res_tag),
		.res     (res)
	);

	// Result beat
	assign done     = res_tag.vld;
	assign in_range = res_tag.ok;
	assign out_x    = $signed(res[LANE_X]);
	assign out_y    = $signed(res[LANE_Y]);

endmodule

// ----- dv/tb_grid_bilinear_index_to_coord.sv -----
`timescale 1ns / 100ps
// Testbench for the grid bilinear mapper: directed edges, cell-count limits, random traffic.
module tb_grid_bilinear_index_to_coord;
	import gbic_pkg::*;

	localparam int     NODES_ACROSS = 256;
	localparam int     NODES_DOWN   = 256;
	localparam longint UNIT         = longint'(1) << FRAC_BITS;
	localparam int     SETTLE       = 16;

	typedef struct packed {
		logic                    cmd;
		logic [IDX_W-1:0]        col;
		logic [IDX_W-1:0]        row;
		logic signed [C_W-1:0]   nx;
		logic signed [C_W-1:0]   ny;
		logic signed [C_W-1:0]   qi;
		logic signed [C_W-1:0]   qj;
	} grid_beat_t;

	typedef struct packed {
		logic signed [C_W-1:0] x;
		logic signed [C_W-1:0] y;
		logic                  ok;
	} coord_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  cmd;
	logic [IDX_W-1:0]      node_col;
	logic [IDX_W-1:0]      node_row;
	logic signed [C_W-1:0] node_x;
	logic signed [C_W-1:0] node_y;
	logic signed [C_W-1:0] query_i;
	logic signed [C_W-1:0] query_j;
	logic                  cfg_we;
	logic [CFG_AW-1:0]     cfg_index;
	logic [IDX_W-1:0]      cfg_wdata;
	logic                  done;
	logic signed [C_W-1:0] out_x;
	logic signed [C_W-1:0] out_y;
	logic                  in_range;

	// Shadow copy of the node grid and the cell counts
	logic signed [C_W-1:0] grid_x [NODES_ACROSS*NODES_DOWN];
	logic signed [C_W-1:0] grid_y [NODES_ACROSS*NODES_DOWN];
	bit                    node_loaded [NODES_ACROSS*NODES_DOWN];
	int                    cells_i_reg;
	int                    cells_j_reg;

	coord_t coord_q [$];
	int     err_cnt;
	int     idle_pct;

	grid_bilinear_index_to_coord #(
		.NODES_ACROSS(NODES_ACROSS),
		.NODES_DOWN  (NODES_DOWN)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.node_col (node_col),
		.node_row (node_row),
		.node_x   (node_x),
		.node_y   (node_y),
		.query_i  (query_i),
		.query_j  (query_j),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.done     (done),
		.out_x    (out_x),
		.out_y    (out_y),
		.in_range (in_range)
	);

	always #6 clk = ~clk;

	// Hard stop if the run hangs
	initial begin
		#5_000_000;
		$display("tb_grid_bilinear_index_to_coord: done, errors");
		$finish;
	end

	// Limit a programmed cell count to what the grid can hold
	function automatic int eff_cells(input int c, input int nodes);
		if (c < 1)
			return 1;
		if (c > nodes - 1)
			return nodes - 1;
		return c;
	endfunction

	// Clamp one index and split it into cell and fraction; clear ok on clamp
	function automatic void split_index(input logic signed [C_W-1:0] q, input int cells,
			output int cell_n, output longint frac, inout bit ok);
		longint v;
		longint top;
		v   = q;
		top = longint'(cells) * UNIT;
		if (v < 0) begin
			v  = 0;
			ok = 1'b0;
		end
		if (v > top) begin
			v  = top - 1;
			ok = 1'b0;
		end
		if (v == top) begin
			cell_n = cells - 1;
			frac   = UNIT;
		end else begin
			cell_n = int'(v >>> FRAC_BITS);
			frac   = v & (UNIT - 1);
		end
	endfunction

	// Exact weighted sum of four corners, floored to the output format
	function automatic logic signed [C_W-1:0] blend_floor(
			input logic signed [C_W-1:0] p00, p10, p01, p11, input longint u, v);
		logic signed [95:0] s00, s10, s01, s11, su, sv, one, acc;
		s00 = p00;
		s10 = p10;
		s01 = p01;
		s11 = p11;
		su  = u;
		sv  = v;
		one = UNIT;
		acc = (s00 * (one - su) + s10 * su) * (one - sv) + (s01 * (one - su) + s11 * su) * sv;
		return acc[C_W+2*FRAC_BITS-1:2*FRAC_BITS];
	endfunction

	function automatic coord_t map_query(input logic signed [C_W-1:0] qi, qj);
		int     ci, cj, a00;
		longint u, v;
		bit     ok;
		coord_t r;
		ok = 1'b1;
		split_index(qi, eff_cells(cells_i_reg, NODES_ACROSS), ci, u, ok);
		split_index(qj, eff_cells(cells_j_reg, NODES_DOWN), cj, v, ok);
		a00  = cj * NODES_ACROSS + ci;
		r.x  = blend_floor(grid_x[a00], grid_x[a00+1], grid_x[a00+NODES_ACROSS],
			grid_x[a00+NODES_ACROSS+1], u, v);
		r.y  = blend_floor(grid_y[a00], grid_y[a00+1], grid_y[a00+NODES_ACROSS],
			grid_y[a00+NODES_ACROSS+1], u, v);
		r.ok = ok;
		return r;
	endfunction

	// Coordinate with a bias toward the extremes
	function automatic logic signed [C_W-1:0] rand_coord();
		case ($urandom_range(7))
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2:       return $urandom_range(255, 0);
			default: return $urandom;
		endcase
	endfunction

	// Index mostly inside the grid, with edges, clamps and raw noise mixed in
	function automatic logic signed [C_W-1:0] rand_index(input int cells);
		longint top;
		longint v;
		top = longint'(cells) * UNIT;
		case ($urandom_range(9))
			0:       v = longint'($urandom_range(cells, 0)) * UNIT;
			1:       v = top;
			2:       v = top + longint'($urandom_range(3, 1));
			3:       v = -longint'($urandom_range(1 << 20, 1));
			4, 5:    v = longint'($signed($urandom));
			default: v = longint'($urandom_range(top, 0));
		endcase
		return v[C_W-1:0];
	endfunction

	// Drive one beat, wait for accept, then update the shadow grid or queue a result
	task automatic send_beat(input grid_beat_t b);
		int a;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		cmd      <= b.cmd;
		node_col <= b.col;
		node_row <= b.row;
		node_x   <= b.nx;
		node_y   <= b.ny;
		query_i  <= b.qi;
		query_j  <= b.qj;
		do @(posedge clk); while (busy);
		if (b.cmd == CMD_WRITE) begin
			a              = b.row * NODES_ACROSS + b.col;
			grid_x[a]      = b.nx;
			grid_y[a]      = b.ny;
			node_loaded[a] = 1'b1;
		end else begin
			coord_q.push_back(map_query(b.qi, b.qj));
		end
	endtask

	task automatic send_node(input int c, input int r, input logic signed [C_W-1:0] x, y);
		grid_beat_t b;
		b.cmd = CMD_WRITE;
		b.col = c[IDX_W-1:0];
		b.row = r[IDX_W-1:0];
		b.nx  = x;
		b.ny  = y;
		b.qi  = $urandom;
		b.qj  = $urandom;
		send_beat(b);
	endtask

	// Load any missing corner of the target cell first, then issue the query
	task automatic send_query(input logic signed [C_W-1:0] qi, qj);
		int         ci, cj;
		longint     u, v;
		bit         ok;
		grid_beat_t b;
		ok = 1'b1;
		split_index(qi, eff_cells(cells_i_reg, NODES_ACROSS), ci, u, ok);
		split_index(qj, eff_cells(cells_j_reg, NODES_DOWN), cj, v, ok);
		for (int dj = 0; dj < 2; dj++)
			for (int di = 0; di < 2; di++)
				if (!node_loaded[(cj + dj) * NODES_ACROSS + ci + di])
					send_node(ci + di, cj + dj, rand_coord(), rand_coord());
		b.cmd = CMD_QUERY;
		b.col = IDX_W'($urandom);
		b.row = IDX_W'($urandom);
		b.nx  = $urandom;
		b.ny  = $urandom;
		b.qi  = qi;
		b.qj  = qj;
		send_beat(b);
	endtask

	// Drop start and hold until every pending result is back and the pipe is quiet
	task automatic drain_results();
		start <= 1'b0;
		while (coord_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input int val);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[IDX_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CELLS_ACROSS)
			cells_i_reg = val & 8'hFF;
		else
			cells_j_reg = val & 8'hFF;
	endtask

	task automatic set_cells(input int across, input int down);
		write_reg(REG_CELLS_ACROSS, across);
		write_reg(REG_CELLS_DOWN, down);
	endtask

	// Small 2x2 grid with checkerboard extremes, then clamps, exact edges and zero count
	task automatic test_directed();
		idle_pct = 0;
		set_cells(2, 2);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				if ((c + r) % 2 == 0)
					send_node(c, r, 32'sh7FFF_FFFF, 32'sh8000_0000);
				else
					send_node(c, r, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_query(0, 0);
		send_query(C_W'(2 * UNIT), C_W'(2 * UNIT));
		send_query(C_W'(2 * UNIT + 1), C_W'(UNIT));
		send_query(-1, C_W'(-UNIT));
		send_query(32'sh7FFF_FFFF, 32'sh8000_0000);
		send_query(C_W'(UNIT + UNIT / 2), C_W'(UNIT / 2));
		send_query(C_W'(UNIT - 1), C_W'(2 * UNIT - 1));
		send_query(C_W'(UNIT), C_W'(UNIT));
		send_query(C_W'(2 * UNIT), 0);
		// a zero count behaves as one cell
		set_cells(0, 0);
		send_query(C_W'(UNIT / 2), C_W'(UNIT / 2));
		send_query(C_W'(UNIT), C_W'(UNIT));
		send_query(C_W'(3 * UNIT), C_W'(UNIT / 3));
		drain_results();
	endtask

	// Random writes and queries under one setting; pause midway until all results are in
	task automatic test_random_traffic(input int pct, input int n_items, input int across,
			input int down);
		set_cells(across, down);
		idle_pct = pct;
		for (int n = 0; n < n_items; n++) begin
			if ($urandom_range(99) < 15)
				send_node($urandom_range(255, 0), $urandom_range(255, 0), rand_coord(),
					rand_coord());
			else
				send_query(rand_index(eff_cells(cells_i_reg, NODES_ACROSS)),
					rand_index(eff_cells(cells_j_reg, NODES_DOWN)));
			if (n == n_items / 2)
				drain_results();
		end
		drain_results();
	endtask

	// Lopsided and extreme cell counts
	task automatic test_cell_limits();
		test_random_traffic(0, 40, 255, 1);
		test_random_traffic(35, 40, 1, 255);
		test_random_traffic(66, 40, 0, 255);
		test_random_traffic(0, 40, 255, 0);
	endtask

	// Compare each result beat against the oldest expectation
	always @(posedge clk) begin : result_check
		coord_t want;
		if (arst_n && done) begin
			if (coord_q.size() == 0) begin
				$error("result with no query pending: out_x %h out_y %h", out_x, out_y);
				err_cnt++;
			end else begin
				want = coord_q.pop_front();
				if (out_x !== want.x) begin
					$error("out_x: expected %h, got %h", want.x, out_x);
					err_cnt++;
				end
				if (out_y !== want.y) begin
					$error("out_y: expected %h, got %h", want.y, out_y);
					err_cnt++;
				end
				if (in_range !== want.ok) begin
					$error("in_range: expected %0d, got %0d", want.ok, in_range);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		err_cnt     = 0;
		idle_pct    = 0;
		cells_i_reg = 255;
		cells_j_reg = 255;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		cmd       <= CMD_WRITE;
		node_col  <= '0;
		node_row  <= '0;
		node_x    <= '0;
		node_y    <= '0;
		query_i   <= '0;
		query_j   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_CELLS_ACROSS;
		cfg_wdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_traffic(0, 130, 3, 5);
		test_random_traffic(66, 130, 255, 255);
		test_random_traffic(35, 130, 1, 1);
		test_random_traffic(0, 130, $urandom_range(254, 2), $urandom_range(254, 2));
		test_cell_limits();
		drain_results();

		if (err_cnt == 0 && coord_q.size() == 0)
			$display("tb_grid_bilinear_index_to_coord: done, clean");
		else
			$display("tb_grid_bilinear_index_to_coord: done, errors");
		$finish;
	end

endmodule

// ----- grid_bilinear_index_to_coord.f -----
design/gbic_pkg.sv
design/gbic_ram.sv
design/gbic_split.sv
design/gbic_blend.sv
design/grid_bilinear_index_to_coord.sv
dv/tb_grid_bilinear_index_to_coord.sv
